FILE: src/sprm_pkg.sv
// Package for the slotted page record manager: sizes, command and status
// codes, and the sequencer state type. No dependencies.
`default_nettype none

package sprm_pkg;

    localparam int PAGE_BYTES       = 4096;
    localparam int SLOT_ENTRY_BYTES = 4;
    localparam int MAX_SLOTS        = 1024;
    localparam int META_FIXED_BYTES = 26;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 13;
    localparam int STS_W  = 2;
    localparam int SUM_W  = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_SPACE = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE    = 2'd2;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_APPEND,
        S_SPACE,
        S_CMP_RD,
        S_CMP_CHK,
        S_RNG,
        S_DEL_CHK,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_QRY_CHK,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/sprm_if.sv
// Handshake interfaces for the command and result channels.
// Depends on sprm_pkg for field widths.
`default_nettype none

interface sprm_cmd_if import sprm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] slot_end;
    logic [LEN_W-1:0] rec_length;
    modport source (output valid, cmd, slot, slot_end, rec_length, input ready);
    modport sink   (input valid, cmd, slot, slot_end, rec_length, output ready);
endinterface

interface sprm_res_if import sprm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  slot_out;
    logic [LEN_W-1:0]  rec_offset;
    logic [LEN_W-1:0]  rec_len_out;
    logic              compacted;
    logic [BYTE_W-1:0] free_bytes;
    modport source (output valid, status, slot_out, rec_offset, rec_len_out, compacted,
                    free_bytes, input ready);
    modport sink   (input valid, status, slot_out, rec_offset, rec_len_out, compacted,
                    free_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/slotted_page_record_manager_top.sv
// Slotted page record manager: slot directory memories and the sequencer
// that walks them. Depends on sprm_pkg and the interfaces in sprm_if.sv.
//
//   channel   dir   words
//   i_cmd     in    one command word: cmd, slot, slot_end, rec_length
//   o_res     out   one result word per command
//
// An insert searches for an empty slot when the directory holds one, else it
// appends a slot, and it compacts the page by walking every directory slot
// when space runs short; a range delete releases or skips each slot in turn,
// and a trim walks back over trailing empty slots. No word is taken while a
// command runs or its result waits.
// Reset (synchronous) empties the page at once; appended slots are cleared as
// they open, so entries at or beyond the directory size are never read.
`default_nettype none

module slotted_page_record_manager_top import sprm_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sprm_cmd_if.sink    i_cmd,
    sprm_res_if.source  o_res
);

    t_state r_state, n_state, r_ret, n_ret;

    // page state
    logic [CNT_W-1:0]  r_dir, n_dir, r_live, n_live;
    logic [BYTE_W-1:0] r_fp, n_fp, r_bu, n_bu;

    // command context
    logic [CNT_W-1:0]  r_s, n_s, r_i, n_i;
    logic [IDX_W-1:0]  r_end, n_end, r_id, n_id;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_off, n_off;
    logic              r_single, n_single, r_app, n_app;

    // result word
    logic [STS_W-1:0]  r_status, n_status;
    logic [IDX_W-1:0]  r_sout, n_sout;
    logic [LEN_W-1:0]  r_roff, n_roff, r_rlen, n_rlen;
    logic              r_comp, n_comp;

    // directory memories
    logic              mem_valid [MAX_SLOTS];
    logic [LEN_W-1:0]  mem_off   [MAX_SLOTS];
    logic [LEN_W-1:0]  mem_len   [MAX_SLOTS];
    logic [IDX_W-1:0]  w_raddr, w_waddr;
    logic              w_we_v, w_wd_v, w_we_o, w_we_l;
    logic [LEN_W-1:0]  w_wd_o;
    logic              r_q_v;
    logic [LEN_W-1:0]  r_q_o, r_q_l;

    // shared arithmetic
    logic [BYTE_W-1:0] w_meta, w_free;
    logic [BYTE_W:0]   w_used;
    logic [SUM_W-1:0]  w_need_sum;
    logic              w_pre_fail, w_app_fail, w_short, w_acc;

    assign w_acc  = i_cmd.valid && i_cmd.ready;
    assign w_meta = BYTE_W'(META_FIXED_BYTES) + {r_dir, 2'b00};
    assign w_used = {1'b0, r_fp} + {1'b0, w_meta};
    assign w_free = (w_used >= (BYTE_W+1)'(PAGE_BYTES)) ? '0
                    : BYTE_W'((BYTE_W+1)'(PAGE_BYTES) - w_used);
    assign w_need_sum = ((r_dir == r_live) ? SUM_W'(SLOT_ENTRY_BYTES) : '0)
                        + SUM_W'(w_meta) + SUM_W'(i_cmd.rec_length) + SUM_W'(r_bu);
    assign w_pre_fail = w_need_sum > SUM_W'(PAGE_BYTES);
    assign w_app_fail = (r_dir >= CNT_W'(MAX_SLOTS))
                        || (SUM_W'(w_used) + SUM_W'(SLOT_ENTRY_BYTES) > SUM_W'(PAGE_BYTES));
    assign w_short    = w_free < BYTE_W'(r_len);

    // pick the read address for this cycle
    always_comb begin
        case (r_state)
            S_IDLE:    w_raddr = i_cmd.slot;
            S_SRCH_RD,
            S_CMP_RD:  w_raddr = r_i[IDX_W-1:0];
            S_TRIM_RD: w_raddr = IDX_W'(r_dir - CNT_W'(1));
            default:   w_raddr = r_s[IDX_W-1:0];
        endcase
    end

    // directory memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_we_v) mem_valid[w_waddr] <= w_wd_v;
        if (w_we_o) mem_off[w_waddr]   <= w_wd_o;
        if (w_we_l) mem_len[w_waddr]   <= r_len;
        r_q_v <= mem_valid[w_raddr];
        r_q_o <= mem_off[w_raddr];
        r_q_l <= mem_len[w_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_cmd.cmd)
                        CMD_INSERT: n_state = w_pre_fail ? S_OUT
                                    : (r_live < r_dir) ? S_SRCH_RD : S_APPEND;
                        CMD_DELETE, CMD_RANGE: n_state = S_RNG;
                        CMD_QUERY:  n_state = ({1'b0, i_cmd.slot} >= r_dir) ? S_OUT
                                    : S_QRY_CHK;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CHK;
            S_SRCH_CHK: begin
                if (!r_q_v) n_state = S_SPACE;
                else if (r_i + CNT_W'(1) >= r_dir) n_state = S_APPEND;
                else n_state = S_SRCH_RD;
            end
            S_APPEND: begin
                if (!w_app_fail) n_state = S_SPACE;
                else if (!r_comp) n_state = S_CMP_RD;
                else n_state = S_OUT;
            end
            S_SPACE:   n_state = (w_short && !r_comp) ? S_CMP_RD : S_OUT;
            S_CMP_RD:  n_state = (r_i >= r_dir) ? r_ret : S_CMP_CHK;
            S_CMP_CHK: n_state = S_CMP_RD;
            S_RNG: begin
                if (r_s > {1'b0, r_end}) n_state = S_OUT;
                else if (r_s >= r_dir) n_state = r_single ? S_OUT : S_RNG;
                else n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (!r_q_v) n_state = S_OUT;
                else if (r_s + CNT_W'(1) == r_dir) n_state = S_TRIM_RD;
                else n_state = S_RNG;
            end
            S_TRIM_RD:  n_state = (r_dir == '0) ? S_RNG : S_TRIM_CHK;
            S_TRIM_CHK: n_state = r_q_v ? S_RNG : S_TRIM_RD;
            S_QRY_CHK:  n_state = S_OUT;
            S_OUT:      n_state = o_res.ready ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    // register updates and memory writes
    always_comb begin
        n_dir = r_dir;   n_live = r_live;  n_fp = r_fp;     n_bu = r_bu;
        n_s = r_s;       n_i = r_i;        n_end = r_end;   n_id = r_id;
        n_len = r_len;   n_off = r_off;    n_single = r_single;
        n_app = r_app;   n_ret = r_ret;
        n_status = r_status; n_sout = r_sout; n_roff = r_roff;
        n_rlen = r_rlen; n_comp = r_comp;
        w_we_v = 1'b0;   w_wd_v = 1'b0;    w_we_o = 1'b0;   w_we_l = 1'b0;
        w_wd_o = '0;     w_waddr = r_s[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status = STS_OK; n_sout = '0; n_roff = '0; n_rlen = '0;
                    n_comp = 1'b0;     n_app = 1'b0; n_i = '0;
                    n_len = i_cmd.rec_length;
                    n_s = {1'b0, i_cmd.slot};
                    n_end = i_cmd.slot_end;
                    n_single = (i_cmd.cmd == CMD_DELETE);
                    case (i_cmd.cmd)
                        CMD_INSERT: if (w_pre_fail) n_status = STS_NO_SPACE;
                        CMD_DELETE: begin
                            n_end = i_cmd.slot;
                            n_sout = i_cmd.slot;
                        end
                        CMD_QUERY: begin
                            n_sout = i_cmd.slot;
                            if ({1'b0, i_cmd.slot} >= r_dir) n_status = STS_RANGE;
                        end
                        CMD_CLEAR: begin
                            n_dir = '0; n_live = '0; n_fp = '0; n_bu = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_CHK: begin
                if (!r_q_v) n_id = r_i[IDX_W-1:0];
                else n_i = r_i + CNT_W'(1);
            end
            S_APPEND: begin
                if (!w_app_fail) begin
                    // open a fresh, empty slot at the end of the directory
                    w_we_v = 1'b1; w_wd_v = 1'b0; w_waddr = r_dir[IDX_W-1:0];
                    n_id = r_dir[IDX_W-1:0];
                    n_dir = r_dir + CNT_W'(1);
                    n_app = 1'b1;
                end else if (!r_comp) begin
                    n_ret = S_APPEND; n_i = '0; n_off = '0;
                end else begin
                    n_status = STS_NO_SPACE;
                end
            end
            S_SPACE: begin
                if (w_short && !r_comp) begin
                    n_ret = S_SPACE; n_i = '0; n_off = '0;
                end else if (w_short) begin
                    if (r_app) n_dir = r_dir - CNT_W'(1);
                    n_status = STS_NO_SPACE;
                end else begin
                    // place the record at the free pointer
                    w_waddr = r_id;
                    w_we_v = 1'b1; w_wd_v = 1'b1;
                    w_we_o = 1'b1; w_wd_o = r_fp[LEN_W-1:0];
                    w_we_l = 1'b1;
                    n_sout = r_id; n_roff = r_fp[LEN_W-1:0]; n_rlen = r_len;
                    n_fp = r_fp + BYTE_W'(r_len);
                    n_bu = r_bu + BYTE_W'(r_len);
                    n_live = r_live + CNT_W'(1);
                end
            end
            S_CMP_RD: begin
                if (r_i >= r_dir) begin
                    n_fp = r_off;
                    n_comp = 1'b1;
                end
            end
            S_CMP_CHK: begin
                // pack live records in slot order
                if (r_q_v) begin
                    w_waddr = r_i[IDX_W-1:0];
                    w_we_o = 1'b1; w_wd_o = r_off[LEN_W-1:0];
                    n_off = r_off + BYTE_W'(r_q_l);
                end
                n_i = r_i + CNT_W'(1);
            end
            S_RNG: begin
                if (r_s <= {1'b0, r_end} && r_s >= r_dir) begin
                    if (r_single) n_status = STS_RANGE;
                    else n_s = r_s + CNT_W'(1);
                end
            end
            S_DEL_CHK: begin
                if (!r_q_v) begin
                    n_status = STS_EMPTY;
                    n_sout = r_s[IDX_W-1:0];
                end else begin
                    // release the slot; trim when it was the last one
                    w_we_v = 1'b1; w_wd_v = 1'b0;
                    n_live = r_live - CNT_W'(1);
                    n_bu = r_bu - BYTE_W'(r_q_l);
                    n_s = r_s + CNT_W'(1);
                    if (r_s + CNT_W'(1) == r_dir) n_dir = r_dir - CNT_W'(1);
                end
            end
            S_TRIM_CHK: if (!r_q_v) n_dir = r_dir - CNT_W'(1);
            S_QRY_CHK: begin
                if (!r_q_v) n_status = STS_EMPTY;
                else begin
                    n_roff = r_q_o;
                    n_rlen = r_q_l;
                end
            end
            default: ;
        endcase
    end

    // hold state and context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= '0;
            r_live  <= '0;
            r_fp    <= '0;
            r_bu    <= '0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_live  <= n_live;
            r_fp    <= n_fp;
            r_bu    <= n_bu;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;       r_i <= n_i;       r_end <= n_end;   r_id <= n_id;
        r_len <= n_len;   r_off <= n_off;   r_single <= n_single;
        r_app <= n_app;   r_ret <= n_ret;
        r_status <= n_status; r_sout <= n_sout; r_roff <= n_roff;
        r_rlen <= n_rlen; r_comp <= n_comp;
    end

    // ports
    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = (r_state == S_OUT);
    assign o_res.status      = r_status;
    assign o_res.slot_out    = r_sout;
    assign o_res.rec_offset  = r_roff;
    assign o_res.rec_len_out = r_rlen;
    assign o_res.compacted   = r_comp;
    assign o_res.free_bytes  = w_free;

`ifndef ASSERT_OFF
    a_live_le_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_dir) else $error("live records exceed directory size");
    a_dir_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir <= CNT_W'(MAX_SLOTS)) else $error("directory overflow");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.ready && o_res.valid)) else $error("command taken while result waits");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !i_cmd.ready) else $error("ready after accept");
`endif

endmodule

`default_nettype wire

FILE: sim/sprm_tb_if.sv
// Testbench copy of nothing: interfaces come from src/sprm_if.sv.
// This file holds the testbench-side helper package; depends on sprm_pkg.
`timescale 1ns / 100ps

package sprm_tb_pkg;
    import sprm_pkg::*;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [IDX_W-1:0]  slot_out;
        logic [LEN_W-1:0]  rec_offset;
        logic [LEN_W-1:0]  rec_len_out;
        logic              compacted;
        logic [BYTE_W-1:0] free_bytes;
    } t_result;
endpackage

FILE: sim/slotted_page_record_manager_top_test.sv
// Testbench for the slotted page record manager: a page model predicts each
// result word, which is compared with the block's output in order.
// Depends on sprm_pkg, sprm_if.sv and sim/sprm_tb_if.sv.
`timescale 1ns / 100ps

module slotted_page_record_manager_top_test;
    import sprm_pkg::*;
    import sprm_tb_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sprm_cmd_if cmd_ch ();
    sprm_res_if res_ch ();

    slotted_page_record_manager_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // Clock, period 8 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Page model state
    bit          pg_valid [MAX_SLOTS];
    int unsigned pg_off   [MAX_SLOTS];
    int unsigned pg_len   [MAX_SLOTS];
    int unsigned pg_dir, pg_live, pg_fp, pg_used;

    t_result expected_words[$];
    int          error_count = 0;
    int unsigned idle_cycles = 0;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;

    function automatic int unsigned meta_bytes();
        return META_FIXED_BYTES + SLOT_ENTRY_BYTES * pg_dir;
    endfunction

    function automatic int unsigned free_space();
        int unsigned u;
        u = pg_fp + meta_bytes();
        return (u >= PAGE_BYTES) ? 0 : PAGE_BYTES - u;
    endfunction

    function automatic void page_clear();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            pg_valid[i] = 0;
            pg_off[i] = 0;
            pg_len[i] = 0;
        end
        pg_dir = 0; pg_live = 0; pg_fp = 0; pg_used = 0;
    endfunction

    // Pack live records from offset 0 in slot order
    function automatic void page_compact();
        int unsigned o;
        o = 0;
        for (int i = 0; i < pg_dir; i++) begin
            if (pg_valid[i]) begin
                pg_off[i] = o & 12'hFFF;
                o += pg_len[i];
            end
        end
        pg_fp = o & 13'h1FFF;
    endfunction

    function automatic int take_slot(output bit appended);
        appended = 0;
        if (pg_live < pg_dir) begin
            for (int i = 0; i < pg_dir; i++)
                if (!pg_valid[i]) return i;
        end
        if (pg_dir >= MAX_SLOTS) return -1;
        if (pg_fp + SLOT_ENTRY_BYTES + meta_bytes() > PAGE_BYTES) return -1;
        pg_valid[pg_dir] = 0;
        pg_dir++;
        appended = 1;
        return pg_dir - 1;
    endfunction

    function automatic logic [STS_W-1:0] drop_slot(int unsigned s);
        if (s >= pg_dir) return STS_RANGE;
        if (!pg_valid[s]) return STS_EMPTY;
        pg_valid[s] = 0;
        pg_live = (pg_live - 1) & 11'h7FF;
        pg_used = (pg_used - pg_len[s]) & 13'h1FFF;
        // Trim trailing empty slots
        if (s + 1 == pg_dir)
            while (pg_dir > 0 && !pg_valid[pg_dir-1]) pg_dir--;
        return STS_OK;
    endfunction

    function automatic t_result page_step(logic [CMD_W-1:0] c, int unsigned s,
                                          int unsigned se, int unsigned len);
        t_result r;
        bit appended;
        int id;
        int unsigned need;
        r = '0;
        case (c)
            CMD_INSERT: begin
                need = (pg_dir == pg_live) ? SLOT_ENTRY_BYTES : 0;
                if (need + meta_bytes() + len + pg_used > PAGE_BYTES) begin
                    r.status = STS_NO_SPACE;
                end else begin
                    id = take_slot(appended);
                    if (id < 0) begin
                        page_compact();
                        r.compacted = 1'b1;
                        id = take_slot(appended);
                    end
                    if (id < 0) begin
                        r.status = STS_NO_SPACE;
                    end else begin
                        if (free_space() < len) begin
                            if (!r.compacted) begin
                                page_compact();
                                r.compacted = 1'b1;
                            end
                            if (free_space() < len) begin
                                if (appended) pg_dir--;
                                r.status = STS_NO_SPACE;
                            end
                        end
                        if (r.status == STS_OK) begin
                            pg_valid[id] = 1;
                            pg_off[id] = pg_fp & 12'hFFF;
                            pg_len[id] = len;
                            r.slot_out = IDX_W'(id);
                            r.rec_offset = LEN_W'(pg_off[id]);
                            r.rec_len_out = LEN_W'(len);
                            pg_fp = (pg_fp + len) & 13'h1FFF;
                            pg_live = (pg_live + 1) & 11'h7FF;
                            pg_used = (pg_used + len) & 13'h1FFF;
                        end
                    end
                end
            end
            CMD_DELETE: begin
                r.slot_out = IDX_W'(s);
                r.status = drop_slot(s);
            end
            CMD_RANGE: begin
                for (int unsigned k = s; k <= se; k++) begin
                    if (k >= pg_dir) continue;
                    if (drop_slot(k) != STS_OK) begin
                        r.status = STS_EMPTY;
                        r.slot_out = IDX_W'(k);
                        break;
                    end
                end
            end
            CMD_QUERY: begin
                r.slot_out = IDX_W'(s);
                if (s >= pg_dir) r.status = STS_RANGE;
                else if (!pg_valid[s]) r.status = STS_EMPTY;
                else begin
                    r.rec_offset = LEN_W'(pg_off[s]);
                    r.rec_len_out = LEN_W'(pg_len[s]);
                end
            end
            CMD_CLEAR: page_clear();
            default: ;
        endcase
        r.free_bytes = BYTE_W'(free_space());
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Drive one command word and wait for it to be taken; valid stays high
    // on the taken word until the next send or a drain replaces it
    task automatic send_word(logic [CMD_W-1:0] c, int unsigned s, int unsigned se,
                             int unsigned len);
        if ($urandom_range(99) < send_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= c;
        cmd_ch.slot       <= IDX_W'(s);
        cmd_ch.slot_end   <= IDX_W'(se);
        cmd_ch.rec_length <= LEN_W'(len);
        do @(posedge i_clk); while (!cmd_ch.ready);
        expected_words.push_back(page_step(c, s, se, len));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    // Receiver stalls, set at each falling edge
    always @(negedge i_clk)
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected", $realtime);
                error_count++;
            end else begin
                automatic t_result w = expected_words.pop_front();
                if (res_ch.status !== w.status)
                    report_mismatch("status", res_ch.status, w.status);
                if (res_ch.slot_out !== w.slot_out)
                    report_mismatch("slot_out", res_ch.slot_out, w.slot_out);
                if (res_ch.rec_offset !== w.rec_offset)
                    report_mismatch("rec_offset", res_ch.rec_offset, w.rec_offset);
                if (res_ch.rec_len_out !== w.rec_len_out)
                    report_mismatch("rec_len_out", res_ch.rec_len_out, w.rec_len_out);
                if (res_ch.compacted !== w.compacted)
                    report_mismatch("compacted", res_ch.compacted, w.compacted);
                if (res_ch.free_bytes !== w.free_bytes)
                    report_mismatch("free_bytes", res_ch.free_bytes, w.free_bytes);
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed: boundaries of every command
    task automatic test_directed();
        send_word(CMD_QUERY, 0, 0, 0);
        send_word(CMD_DELETE, 1023, 0, 0);
        send_word(CMD_INSERT, 0, 0, 0);
        send_word(CMD_INSERT, 0, 0, 100);
        send_word(CMD_INSERT, 0, 0, 4095);
        send_word(CMD_INSERT, 1023, 1023, 200);
        send_word(CMD_QUERY, 1, 0, 0);
        send_word(CMD_QUERY, 3, 0, 0);
        send_word(CMD_DELETE, 1, 0, 0);
        send_word(CMD_DELETE, 1, 0, 0);
        send_word(CMD_QUERY, 1, 0, 0);
        send_word(CMD_INSERT, 0, 0, 50);
        send_word(CMD_RANGE, 2, 1, 0);
        send_word(CMD_RANGE, 0, 1023, 0);
        send_word(CMD_INSERT, 0, 0, 3000);
        send_word(CMD_INSERT, 0, 0, 900);
        send_word(CMD_DELETE, 0, 0, 0);
        send_word(CMD_INSERT, 0, 0, 1000);
        send_word(CMD_QUERY, 0, 0, 0);
        send_word(3'd5, 1023, 1023, 4095);
        send_word(3'd7, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_QUERY, 0, 0, 0);
    endtask

    // Random: mostly small inserts and deletes so the directory grows deep
    task automatic test_random(int n);
        int unsigned k, c, s, se, len;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            s  = (pg_dir > 0 && $urandom_range(9) < 8) ? $urandom_range(pg_dir) : $urandom;
            se = ($urandom_range(3) == 0) ? $urandom : s + $urandom_range(8);
            len = ($urandom_range(19) == 0) ? $urandom : $urandom_range(64);
            if (k < 45) c = CMD_INSERT;
            else if (k < 70) c = CMD_DELETE;
            else if (k < 78) c = CMD_RANGE;
            else if (k < 96) c = CMD_QUERY;
            else if (k < 97) c = CMD_CLEAR;
            else c = $urandom_range(7);
            send_word(CMD_W'(c), s & 10'h3FF, se & 10'h3FF, len & 12'hFFF);
        end
    endtask

    // Fill the page with tiny records to push the directory and compaction
    task automatic test_fill_page();
        send_word(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < 120; i++)
            send_word(CMD_INSERT, 0, 0, $urandom_range(40));
        for (int i = 0; i < 40; i++)
            send_word(CMD_DELETE, $urandom_range(pg_dir), 0, 0);
        for (int i = 0; i < 40; i++)
            send_word(CMD_INSERT, 0, 0, $urandom_range(80));
        drain_results();
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_QUERY;
        cmd_ch.slot = '0;
        cmd_ch.slot_end = '0;
        cmd_ch.rec_length = '0;
        res_ch.ready = 1'b0;
        page_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 9; recv_gap_pct = 87;
        test_directed();
        drain_results();
        test_random(500);
        test_fill_page();
        send_gap_pct = 87; recv_gap_pct = 9;
        test_random(450);
        send_gap_pct = 0; recv_gap_pct = 0;
        test_random(550);

        drain_results();
        repeat (100) @(negedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: sim.f
src/sprm_pkg.sv
src/sprm_if.sv
src/slotted_page_record_manager_top.sv
sim/sprm_tb_if.sv
sim/slotted_page_record_manager_top_test.sv
